// ===== src/ifmt_pkg.sv =====
// Package for the integer-to-text formatter: field widths, ASCII codes,
// sequencer states and the digit-to-character mapping.
// No dependencies.
`default_nettype none

package ifmt_pkg;

  localparam int RADIX_W       = 6;   // radix field width
  localparam int SPEC_W        = 6;   // width and min_digits field width
  localparam int FLAG_COUNT    = 7;   // single-bit option flags in the input
  localparam int CHAR_W        = 8;
  localparam int BITS_PER_STEP = 8;   // quotient bits resolved per divider cycle
  localparam int OUT_MAX       = 48;  // characters emitted per number at most

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_EMIT,
    ST_ERR
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DEC_DIGITS) begin
      digit_char = CH_ZERO + d_ext;
    end else begin
      digit_char = (upper ? CH_UP_A : CH_LO_A) + d_ext - CHAR_W'(DEC_DIGITS);
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/ifmt_divider.sv =====
// Shared iterative divider: divides a value by the radix, eight quotient
// bits per cycle, by restoring compare-and-subtract. Uses ifmt_pkg.
`default_nettype none

module ifmt_divider
  import ifmt_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]    divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [RADIX_W-1:0]         remainder
);

  localparam int STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W  = STEPS * BITS_PER_STEP;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]         q_reg;
  logic [RADIX_W-1:0]       rem_reg;
  logic [RADIX_W-1:0]       div_reg;
  logic [STEP_W-1:0]        cnt;
  logic                     busy;
  logic [RADIX_W-1:0]       rem_work;
  logic [BITS_PER_STEP-1:0] q_bits;

  // Resolve the next group of quotient bits from the top of the shift register
  always_comb begin
    logic [RADIX_W:0] t;
    rem_work = rem_reg;
    q_bits   = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {rem_work, q_reg[DIV_W-1-i]};
      if (t >= {1'b0, div_reg}) begin
        rem_work                    = RADIX_W'(t - {1'b0, div_reg});
        q_bits[BITS_PER_STEP-1-i]   = 1'b1;
      end else begin
        rem_work                    = t[RADIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_reg   <= DIV_W'(dividend);
      rem_reg <= '0;
      div_reg <= divisor;
    end else if (busy) begin
      q_reg   <= (q_reg << BITS_PER_STEP) | DIV_W'(q_bits);
      rem_reg <= rem_work;
    end
  end

  assign quotient  = q_reg[VALUE_BITS-1:0];
  assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/ifmt_digit_stack.sv =====
// Digit stack: digit characters are pushed least significant first and
// popped most significant first. Uses ifmt_pkg.
`default_nettype none

module ifmt_digit_stack
  import ifmt_pkg::*;
#(
  parameter int DIGIT_SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              push,
  input  wire logic              pop,
  input  wire logic [CHAR_W-1:0] push_char,
  output logic [CHAR_W-1:0]      top_char
);

  logic [CHAR_W-1:0] slot [DIGIT_SLOTS];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[0] <= push_char;
      for (int i = 1; i < DIGIT_SLOTS; i++) begin
        slot[i] <= slot[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign top_char = slot[0];

endmodule

`default_nettype wire

// ===== src/integer_to_padded_text_formatter.sv =====
// Integer-to-text formatter, printf style: sign, alternate prefix, minimum
// digit count and field width padding, one ASCII character per output
// transaction. An input is taken only in idle. Each digit costs one pass of
// the shared divider; digit extraction stops once the quotient is zero or
// DIGIT_SLOTS digits exist. The ST_CALC state then fixes the layout, and
// characters follow one per cycle while the output is taken. A radix
// outside 2..36 gives one NUL character (8'h00) with tlast and tuser set.
// Digits are held in a shift stack, so no memory clearing pass is needed
// after reset. Depends on ifmt_pkg, ifmt_divider and ifmt_digit_stack.
`default_nettype none

module integer_to_padded_text_formatter
  import ifmt_pkg::*;
#(
  parameter int VALUE_BITS      = 32,
  parameter int DIGIT_SLOTS     = 32,
  parameter int MAX_FIELD_WIDTH = 48,
  parameter int MAX_PRECISION   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // value, radix[6], width[6], min_digits[6], signed_mode, zero_pad,
  // plus_sign, space_sign, left_justify, alt_prefix, upper_case, zero fill
  input  wire logic [((VALUE_BITS + 3 * SPEC_W + FLAG_COUNT + 7) / 8) * 8 - 1:0]
                    s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,  // out_char
  output logic      m_axis_tlast,          // last
  output logic      m_axis_tuser           // bad_radix
);

  localparam int ND_W  = $clog2(DIGIT_SLOTS + 1);
  localparam int CNT_W = $clog2(MAX_FIELD_WIDTH + MAX_PRECISION + DIGIT_SLOTS + OUT_MAX);
  localparam int F_RADIX = VALUE_BITS;
  localparam int F_WIDTH = F_RADIX + RADIX_W;
  localparam int F_PREC  = F_WIDTH + SPEC_W;
  localparam int F_FLAGS = F_PREC + SPEC_W;

  // input fields
  logic [VALUE_BITS-1:0] in_value;
  logic [RADIX_W-1:0]    in_radix;
  logic [SPEC_W-1:0]     in_width;
  logic [SPEC_W-1:0]     in_prec;
  logic                  in_signed, in_zpad, in_plus, in_space, in_left, in_alt, in_upper;
  logic                  in_neg, in_bad;
  logic [VALUE_BITS-1:0] in_mag;
  logic [CNT_W-1:0]      in_w_ext, in_p_ext;

  assign in_value  = s_axis_tdata[VALUE_BITS-1:0];
  assign in_radix  = s_axis_tdata[F_RADIX +: RADIX_W];
  assign in_width  = s_axis_tdata[F_WIDTH +: SPEC_W];
  assign in_prec   = s_axis_tdata[F_PREC +: SPEC_W];
  assign in_signed = s_axis_tdata[F_FLAGS];
  assign in_zpad   = s_axis_tdata[F_FLAGS + 1];
  assign in_plus   = s_axis_tdata[F_FLAGS + 2];
  assign in_space  = s_axis_tdata[F_FLAGS + 3];
  assign in_left   = s_axis_tdata[F_FLAGS + 4];
  assign in_alt    = s_axis_tdata[F_FLAGS + 5];
  assign in_upper  = s_axis_tdata[F_FLAGS + 6];

  assign in_neg   = in_signed & in_value[VALUE_BITS-1];
  assign in_mag   = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
  assign in_bad   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  assign in_w_ext = CNT_W'(in_width);
  assign in_p_ext = CNT_W'(in_prec);

  // registers
  state_t             state, state_next;
  logic [RADIX_W-1:0] radix, radix_next;
  logic [CNT_W-1:0]   w_lim, w_lim_next;
  logic [CNT_W-1:0]   p_lim, p_lim_next;
  logic [CHAR_W-1:0]  sign_ch, sign_ch_next;
  logic               sign_pend, sign_pend_next;
  logic               pre0, pre0_next;
  logic               prex, prex_next;
  logic               zpad, zpad_next;
  logic               left, left_next;
  logic               upper, upper_next;
  logic [ND_W-1:0]    nd, nd_next;
  logic [CNT_W-1:0]   pad_cnt, pad_cnt_next;
  logic [CNT_W-1:0]   prec_cnt, prec_cnt_next;
  logic [CNT_W-1:0]   total_left, total_left_next;
  logic               m_tvalid_next;
  logic [CHAR_W-1:0]  m_tdata_next;
  logic               m_tlast_next, m_tuser_next;

  // divider and stack hookup
  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] div_dividend, div_quot;
  logic [RADIX_W-1:0]    div_rem;
  logic                  stk_push, stk_pop;
  logic [CHAR_W-1:0]     stk_top;

  // layout terms
  logic [CNT_W-1:0] nd_ext, prec_eff, used, pad_len, total;
  logic             out_free;

  ifmt_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_start && state == ST_IDLE ? in_radix : radix),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  ifmt_digit_stack #(
    .DIGIT_SLOTS(DIGIT_SLOTS)
  ) u_stack (
    .clk      (clk),
    .push     (stk_push),
    .pop      (stk_pop),
    .push_char(digit_char(div_rem, upper)),
    .top_char (stk_top)
  );

  assign nd_ext   = CNT_W'(nd);
  assign prec_eff = (p_lim > nd_ext) ? p_lim : nd_ext;
  assign used     = CNT_W'(sign_pend) + CNT_W'(pre0) + CNT_W'(prex) + prec_eff;
  assign pad_len  = (w_lim > used) ? (w_lim - used) : '0;
  assign total    = used + pad_len;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next      = state;
    radix_next      = radix;
    w_lim_next      = w_lim;
    p_lim_next      = p_lim;
    sign_ch_next    = sign_ch;
    sign_pend_next  = sign_pend;
    pre0_next       = pre0;
    prex_next       = prex;
    zpad_next       = zpad;
    left_next       = left;
    upper_next      = upper;
    nd_next         = nd;
    pad_cnt_next    = pad_cnt;
    prec_cnt_next   = prec_cnt;
    total_left_next = total_left;
    m_tvalid_next   = m_axis_tvalid && !m_axis_tready;
    m_tdata_next    = m_axis_tdata;
    m_tlast_next    = m_axis_tlast;
    m_tuser_next    = m_axis_tuser;
    div_start       = 1'b0;
    div_dividend    = div_quot;
    stk_push        = 1'b0;
    stk_pop         = 1'b0;
    s_axis_tready   = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          radix_next = in_radix;
          w_lim_next = (in_w_ext > CNT_W'(MAX_FIELD_WIDTH)) ? CNT_W'(MAX_FIELD_WIDTH)
                                                            : in_w_ext;
          p_lim_next = (in_p_ext > CNT_W'(MAX_PRECISION)) ? CNT_W'(MAX_PRECISION)
                                                          : in_p_ext;
          if (in_neg) begin
            sign_ch_next = CH_MINUS;
          end else if (in_plus) begin
            sign_ch_next = CH_PLUS;
          end else begin
            sign_ch_next = CH_SPACE;
          end
          sign_pend_next = in_signed && (in_neg || in_plus || in_space);
          pre0_next      = in_alt && (in_radix == RADIX_OCT || in_radix == RADIX_HEX);
          prex_next      = in_alt && (in_radix == RADIX_HEX);
          zpad_next      = in_zpad && !in_left;
          left_next      = in_left;
          upper_next     = in_upper;
          nd_next        = '0;
          if (in_bad) begin
            state_next = ST_ERR;
          end else begin
            div_start    = 1'b1;
            div_dividend = in_mag;
            state_next   = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          stk_push = 1'b1;
          nd_next  = nd + ND_W'(1);
          // keep dividing while quotient bits remain and slots are free
          if ((div_quot != '0) && ((nd + ND_W'(1)) < ND_W'(DIGIT_SLOTS))) begin
            div_start = 1'b1;
          end else begin
            state_next = ST_CALC;
          end
        end
      end

      ST_CALC: begin
        prec_cnt_next   = prec_eff - nd_ext;
        pad_cnt_next    = pad_len;
        total_left_next = (total > CNT_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : total;
        state_next      = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          m_tvalid_next   = 1'b1;
          m_tuser_next    = 1'b0;
          m_tlast_next    = (total_left == CNT_W'(1));
          total_left_next = total_left - CNT_W'(1);
          if (total_left == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
          if (!zpad && !left && pad_cnt != '0) begin
            m_tdata_next = CH_SPACE;
            pad_cnt_next = pad_cnt - CNT_W'(1);
          end else if (sign_pend) begin
            m_tdata_next   = sign_ch;
            sign_pend_next = 1'b0;
          end else if (pre0) begin
            m_tdata_next = CH_ZERO;
            pre0_next    = 1'b0;
          end else if (prex) begin
            m_tdata_next = upper ? CH_UP_X : CH_LO_X;
            prex_next    = 1'b0;
          end else if (zpad && pad_cnt != '0) begin
            m_tdata_next = CH_ZERO;
            pad_cnt_next = pad_cnt - CNT_W'(1);
          end else if (prec_cnt != '0) begin
            m_tdata_next  = CH_ZERO;
            prec_cnt_next = prec_cnt - CNT_W'(1);
          end else if (nd != '0) begin
            m_tdata_next = stk_top;
            stk_pop      = 1'b1;
            nd_next      = nd - ND_W'(1);
          end else begin
            m_tdata_next = CH_SPACE;
            pad_cnt_next = pad_cnt - CNT_W'(1);
          end
        end
      end

      ST_ERR: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = CH_NUL;
          m_tlast_next  = 1'b1;
          m_tuser_next  = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      m_axis_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    radix        <= radix_next;
    w_lim        <= w_lim_next;
    p_lim        <= p_lim_next;
    sign_ch      <= sign_ch_next;
    sign_pend    <= sign_pend_next;
    pre0         <= pre0_next;
    prex         <= prex_next;
    zpad         <= zpad_next;
    left         <= left_next;
    upper        <= upper_next;
    nd           <= nd_next;
    pad_cnt      <= pad_cnt_next;
    prec_cnt     <= prec_cnt_next;
    total_left   <= total_left_next;
    m_axis_tdata <= m_tdata_next;
    m_axis_tlast <= m_tlast_next;
    m_axis_tuser <= m_tuser_next;
  end

endmodule

`default_nettype wire
